FILE: rtl/sms_pkg.sv
package sms_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int REQ_W       = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2
    } req_t;

    // One request walking down the row of cells.
    typedef struct packed {
        logic                  vld;
        req_t                  kind;
        logic [VALUE_BITS-1:0] value;
        logic                  found;
        logic                  free_seen;
        logic [IDX_W-1:0]      free_idx;
    } token_t;

    // Slot write issued to place a new value in a free slot.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [VALUE_BITS-1:0] value;
    } wr_cmd_t;

endpackage

FILE: rtl/sms_cell.sv
module sms_cell
    import sms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  token_t           tok_in,
    input  wr_cmd_t          wr,
    output token_t           tok_out
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;
    token_t                tok_reg;
    token_t                tok_next;
    logic                  match;
    logic                  wr_hit;

    assign match  = tok_in.vld && valid_reg && (value_reg == tok_in.value);
    assign wr_hit = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (wr_hit)
        begin
            valid_next = 1'b1;
            value_next = wr.value;
        end
        if (match && (tok_in.kind == REQ_REMOVE))
        begin
            valid_next = 1'b0;
        end

        tok_next       = tok_in;
        tok_next.found = tok_in.found | match;
        if (tok_in.vld && !tok_in.free_seen && !valid_reg)
        begin
            tok_next.free_seen = 1'b1;
            tok_next.free_idx  = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign tok_out = tok_reg;

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (match && (tok_in.kind == REQ_REMOVE)) |=> !valid_reg)
        else $error("Matching remove did not clear the slot.");

    a_write_sets: assert property (@(posedge clk) disable iff (!rst_n)
        wr_hit |=> (valid_reg && (value_reg == $past(wr.value))))
        else $error("Slot write was not stored.");

    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.vld && tok_in.found) |=> (tok_out.vld && tok_out.found))
        else $error("Hit flag lost along the row.");

endmodule

FILE: rtl/set_membership_store.sv
// An accepted item passes the input token register, the token register of every cell and the result registers.
// The request walks the row of cells, one a cycle; no new item is taken while one is in the row.
// busy is high from acceptance until the cycle in which done pulses; a new item may start then.
// Results are shown for one cycle with done high; the receiver cannot stall them.
// Reset clears every valid mark and the count; stored values stay undefined until written.
module set_membership_store
    import sms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [REQ_W-1:0]          req_type,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      busy,
    output logic                      done,
    output logic                      success,
    output logic                      full_reject,
    output logic [COUNT_OUT_W-1:0]    count,
    output logic                      empty_res
);

    token_t               tok [0:CAPACITY];
    token_t               tok0_reg;
    token_t               tok0_next;
    token_t               last;
    wr_cmd_t              wr_reg;
    wr_cmd_t              wr_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 success_reg;
    logic                 success_next;
    logic                 full_reject_reg;
    logic                 full_reject_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 accept;

    assign accept = start && !busy_reg;
    assign tok[0] = tok0_reg;
    assign last   = tok[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sms_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .tok_in   (tok[i]),
            .wr       (wr_reg),
            .tok_out  (tok[i+1])
        );
    end

    always_comb
    begin
        tok0_next           = '0;
        tok0_next.vld       = accept;
        tok0_next.kind      = req_t'(req_type);
        tok0_next.value     = VALUE_BITS'($unsigned(value));

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (last.vld)
        begin
            busy_next = 1'b0;
        end

        success_next     = 1'b0;
        full_reject_next = 1'b0;
        count_next       = count_reg;
        wr_next          = '0;
        if (last.vld)
        begin
            case (last.kind)
                REQ_ADD:
                begin
                    if (!last.found)
                    begin
                        if (last.free_seen)
                        begin
                            wr_next.en    = 1'b1;
                            wr_next.idx   = last.free_idx;
                            wr_next.value = last.value;
                            count_next    = count_reg + 1'b1;
                            success_next  = 1'b1;
                        end
                        else
                        begin
                            full_reject_next = 1'b1;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (last.found)
                    begin
                        count_next   = count_reg - 1'b1;
                        success_next = 1'b1;
                    end
                end
                REQ_SEARCH:
                begin
                    success_next = last.found;
                end
                default:
                begin
                    success_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg        <= '0;
            wr_reg          <= '0;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            success_reg     <= 1'b0;
            full_reject_reg <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            tok0_reg        <= tok0_next;
            wr_reg          <= wr_next;
            busy_reg        <= busy_next;
            done_reg        <= last.vld;
            success_reg     <= success_next;
            full_reject_reg <= full_reject_next;
            count_reg       <= count_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign success     = success_reg;
    assign full_reject = full_reject_reg;
    assign count       = COUNT_OUT_W'(count_reg);
    assign empty_res   = (count_reg == '0);

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("Result shown while still busy.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("Accepted item did not raise busy.");

    a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(success_reg && full_reject_reg))
        else $error("Success and full reject raised together.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("Stored count exceeds capacity.");

endmodule
